// ===== src/oprm_pkg.sv =====
// ----------------------------------------------------------------------------
// oprm_pkg
// Shared codes and control types for the ordered pattern rule matcher.
// ----------------------------------------------------------------------------
package oprm_pkg;

    // Input word kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_PATTERN = 2'd1,
        KIND_DELETE  = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Result word kinds.
    typedef enum logic [1:0] {
        RK_MATCH  = 2'd0,
        RK_ADD    = 2'd1,
        RK_DELETE = 2'd2,
        RK_UNUSED = 2'd3
    } reply_kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Rule actions.
    localparam logic [1:0] ACT_DROP = 2'd2;

    // Per-cycle control handed from the sequencer to one rule cell.
    typedef struct packed {
        logic valid;      // cell holds a live rule
        logic payload;    // a payload word is inspected this cycle
        logic clear_hit;  // buffer ends: drop the hit flag
        logic load;       // shift a pattern byte into this cell
        logic commit;     // rule completes: take id, action and length
        logic take_next;  // delete: copy the upper neighbor
    } cell_ctrl_t;

endpackage

// ===== src/oprm_cell.sv =====
// ----------------------------------------------------------------------------
// oprm_cell
// One rule slot: pattern bytes (newest byte at index 0), length, id, action
// and hit flag, compared against the shared byte window every payload word.
// ----------------------------------------------------------------------------
module oprm_cell #(
    parameter int MAX_PATTERN = 64,
    parameter int LW          = 7
) (
    input  logic                     aclk,
    input  oprm_pkg::cell_ctrl_t     ctrl,
    input  logic [7:0]               data_byte,
    input  logic [15:0]              new_id,
    input  logic [1:0]               new_action,
    input  logic [LW-1:0]            new_len,
    input  logic [MAX_PATTERN*8-1:0] window,
    input  logic [LW-1:0]            window_fill,
    input  logic [MAX_PATTERN*8-1:0] nb_pattern,
    input  logic [LW-1:0]            nb_len,
    input  logic [15:0]              nb_id,
    input  logic [1:0]               nb_action,
    input  logic                     nb_hit,
    output logic [MAX_PATTERN*8-1:0] pattern,
    output logic [LW-1:0]            len,
    output logic [15:0]              id,
    output logic [1:0]               action,
    output logic                     hit,
    output logic                     hit_upd
);
    import oprm_pkg::*;

    logic [MAX_PATTERN*8-1:0] pattern_reg, pattern_next;
    logic [LW-1:0]            len_reg, len_next;
    logic [15:0]              id_reg, id_next;
    logic [1:0]               action_reg, action_next;
    logic                     hit_reg, hit_next;
    logic [MAX_PATTERN-1:0]   byte_ok;
    logic                     match;

    // Byte k of the pattern, counted from its end, against the k-th newest byte.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            byte_ok[k] = (LW'(k) >= len_reg) ||
                         (pattern_reg[k*8 +: 8] == window[k*8 +: 8]);
        end
    end

    assign match   = ctrl.valid && ctrl.payload && (len_reg != '0) &&
                     (len_reg <= window_fill) && (&byte_ok);
    assign hit_upd = ctrl.valid && (hit_reg || match);

    // Next state of the slot.
    always_comb begin
        pattern_next = pattern_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        action_next  = action_reg;
        hit_next     = hit_reg;
        if (ctrl.take_next) begin
            pattern_next = nb_pattern;
            len_next     = nb_len;
            id_next      = nb_id;
            action_next  = nb_action;
            hit_next     = nb_hit;
        end else begin
            if (ctrl.load) begin
                pattern_next = {pattern_reg[MAX_PATTERN*8-9:0], data_byte};
            end
            if (ctrl.commit) begin
                len_next    = new_len;
                id_next     = new_id;
                action_next = new_action;
                hit_next    = 1'b0;
            end else if (ctrl.payload) begin
                hit_next = ctrl.clear_hit ? 1'b0 : (hit_reg || match);
            end
        end
    end

    always_ff @(posedge aclk) begin
        pattern_reg <= pattern_next;
        len_reg     <= len_next;
        id_reg      <= id_next;
        action_reg  <= action_next;
        hit_reg     <= hit_next;
    end

    assign pattern = pattern_reg;
    assign len     = len_reg;
    assign id      = id_reg;
    assign action  = action_reg;
    assign hit     = hit_reg;

endmodule

// ===== src/ordered_pattern_rule_matcher_top.sv =====
// ----------------------------------------------------------------------------
// ordered_pattern_rule_matcher_top
// Ordered table of byte patterns matched against streamed payload buffers.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries one word per handshake. Kind 0 words stream
// payload bytes; the word with s_last set closes the buffer and yields one
// match verdict naming the lowest-ordered rule whose pattern occurred in it.
// Kind 1 words stream the bytes of a new rule; its last word yields an add
// acknowledgment with the assigned id or a full / too-long status. Kind 2
// deletes the first rule with s_target_id and always yields an acknowledgment.
// Kind 3 is ignored.
// Each word is taken and fully processed by a chain of rule cells, one per
// rule, all comparing the shared byte window in parallel; a delete shifts
// every cell above the removed one down by one. Throughput is one word per
// cycle while s_ready is high; a result appears on the m_ channel in the
// cycle after the word that caused it. The result sits in a single output
// register, so a stalled receiver holds s_ready low only while it is full
// and not being taken. Reset empties the table, zeroes the id counter and
// drops any partial buffer or pattern load; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_pattern_rule_matcher_top #(
    parameter int NUM_RULES   = 16,
    parameter int MAX_PATTERN = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    input  logic [1:0]  s_new_action,
    input  logic [15:0] s_target_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_reply_kind,
    output logic        m_matched,
    output logic [15:0] m_rule_id,
    output logic [1:0]  m_rule_act,
    output logic [1:0]  m_status
);
    import oprm_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = $clog2(NUM_RULES + 1);

    // Shared state.
    logic [MAX_PATTERN*8-1:0] window_reg, window_next;
    logic [LW-1:0]            fill_reg, fill_next, fill_now;
    logic [CW-1:0]            count_reg, count_next;
    logic [15:0]              next_id_reg, next_id_next;
    logic [LW-1:0]            load_len_reg, load_len_next;
    logic                     load_ovf_reg, load_ovf_next;
    logic                     load_blk_reg, load_blk_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_reply_kind_reg, m_reply_kind_next;
    logic        m_matched_reg, m_matched_next;
    logic [15:0] m_rule_id_reg, m_rule_id_next;
    logic [1:0]  m_rule_act_reg, m_rule_act_next;
    logic [1:0]  m_status_reg, m_status_next;

    // Cell chain wiring; index NUM_RULES is the empty slot above the top cell.
    cell_ctrl_t               ctrl [NUM_RULES];
    logic [MAX_PATTERN*8-1:0] c_pattern [NUM_RULES+1];
    logic [LW-1:0]            c_len     [NUM_RULES+1];
    logic [15:0]              c_id      [NUM_RULES+1];
    logic [1:0]               c_action  [NUM_RULES+1];
    logic [NUM_RULES:0]       c_hit;
    logic [NUM_RULES-1:0]     c_hit_upd;
    logic [NUM_RULES-1:0]     del_hit, del_shift;

    logic       accept;
    logic       is_payload, is_pattern, is_delete;
    logic       table_full, blocked, load_first, overflow, add_ok, del_found;
    logic [1:0] act_sat;

    assign accept     = s_valid && s_ready;
    assign s_ready    = !m_valid_reg || m_ready;
    assign is_payload = accept && (s_kind == KIND_PAYLOAD);
    assign is_pattern = accept && (s_kind == KIND_PATTERN);
    assign is_delete  = accept && (s_kind == KIND_DELETE);

    // Window with the incoming payload byte shifted in at the newest end.
    assign window_next = {window_reg[MAX_PATTERN*8-9:0], s_data_byte};
    assign fill_now    = (fill_reg == LW'(MAX_PATTERN)) ? fill_reg : fill_reg + 1'b1;

    // Pattern load bookkeeping.
    assign table_full = (count_reg >= CW'(NUM_RULES));
    assign load_first = (load_len_reg == '0) && !load_ovf_reg;
    assign blocked    = load_first ? table_full : load_blk_reg;
    assign overflow   = load_ovf_reg || (load_len_reg >= LW'(MAX_PATTERN));
    assign add_ok     = !blocked && !table_full && !overflow;
    assign act_sat    = (s_new_action == 2'd3) ? ACT_DROP : s_new_action;

    // Delete search: the first live cell with the id and all cells above it.
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int j = 0; j < NUM_RULES; j++) begin
            del_hit[j]   = (CW'(j) < count_reg) && (c_id[j] == s_target_id);
            seen         = seen || del_hit[j];
            del_shift[j] = seen;
        end
    end
    assign del_found = |del_hit;

    // Per-cell control.
    always_comb begin
        for (int j = 0; j < NUM_RULES; j++) begin
            ctrl[j].valid     = (CW'(j) < count_reg);
            ctrl[j].payload   = is_payload;
            ctrl[j].clear_hit = is_payload && s_last;
            ctrl[j].load      = is_pattern && !blocked && !table_full &&
                                (load_len_reg < LW'(MAX_PATTERN)) && (CW'(j) == count_reg);
            ctrl[j].commit    = is_pattern && s_last && add_ok && (CW'(j) == count_reg);
            ctrl[j].take_next = is_delete && del_shift[j];
        end
    end

    assign c_pattern[NUM_RULES] = '0;
    assign c_len[NUM_RULES]     = '0;
    assign c_id[NUM_RULES]      = '0;
    assign c_action[NUM_RULES]  = '0;
    assign c_hit[NUM_RULES]     = 1'b0;

    // The chain of rule cells.
    for (genvar g = 0; g < NUM_RULES; g++) begin : g_cell
        oprm_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .LW          (LW)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl[g]),
            .data_byte   (s_data_byte),
            .new_id      (next_id_reg),
            .new_action  (act_sat),
            .new_len     (load_len_reg + 1'b1),
            .window      (window_next),
            .window_fill (fill_now),
            .nb_pattern  (c_pattern[g+1]),
            .nb_len      (c_len[g+1]),
            .nb_id       (c_id[g+1]),
            .nb_action   (c_action[g+1]),
            .nb_hit      (c_hit[g+1]),
            .pattern     (c_pattern[g]),
            .len         (c_len[g]),
            .id          (c_id[g]),
            .action      (c_action[g]),
            .hit         (c_hit[g]),
            .hit_upd     (c_hit_upd[g])
        );
    end

    // Shared state update.
    always_comb begin
        fill_next     = fill_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        load_len_next = load_len_reg;
        load_ovf_next = load_ovf_reg;
        load_blk_next = load_blk_reg;
        if (is_payload) begin
            fill_next = s_last ? '0 : fill_now;
        end
        if (is_pattern) begin
            if (s_last) begin
                load_len_next = '0;
                load_ovf_next = 1'b0;
                load_blk_next = 1'b0;
                if (add_ok) begin
                    count_next   = count_reg + 1'b1;
                    next_id_next = next_id_reg + 16'd1;
                end
            end else begin
                load_blk_next = blocked;
                if (load_len_reg < LW'(MAX_PATTERN)) begin
                    load_len_next = load_len_reg + 1'b1;
                end else begin
                    load_ovf_next = 1'b1;
                end
            end
        end
        if (is_delete && del_found) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Result formation.
    always_comb begin
        m_valid_next      = m_valid_reg && !m_ready;
        m_reply_kind_next = m_reply_kind_reg;
        m_matched_next    = m_matched_reg;
        m_rule_id_next    = m_rule_id_reg;
        m_rule_act_next   = m_rule_act_reg;
        m_status_next     = m_status_reg;
        if (is_payload && s_last) begin
            m_valid_next      = 1'b1;
            m_reply_kind_next = RK_MATCH;
            m_matched_next    = 1'b0;
            m_rule_id_next    = '0;
            m_rule_act_next   = '0;
            m_status_next     = ST_OK;
            for (int j = NUM_RULES - 1; j >= 0; j--) begin
                if (c_hit_upd[j]) begin
                    m_matched_next  = 1'b1;
                    m_rule_id_next  = c_id[j];
                    m_rule_act_next = c_action[j];
                end
            end
        end else if (is_pattern && s_last) begin
            m_valid_next      = 1'b1;
            m_reply_kind_next = RK_ADD;
            m_matched_next    = 1'b0;
            m_rule_act_next   = '0;
            m_rule_id_next    = add_ok ? next_id_reg : 16'd0;
            if (blocked || table_full) begin
                m_status_next = ST_FULL;
            end else if (overflow) begin
                m_status_next = ST_TOO_LONG;
            end else begin
                m_status_next = ST_OK;
            end
        end else if (is_delete) begin
            m_valid_next      = 1'b1;
            m_reply_kind_next = RK_DELETE;
            m_matched_next    = 1'b0;
            m_rule_id_next    = s_target_id;
            m_rule_act_next   = '0;
            m_status_next     = del_found ? ST_OK : ST_NOT_FOUND;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            count_reg    <= '0;
            next_id_reg  <= '0;
            load_len_reg <= '0;
            load_ovf_reg <= 1'b0;
            load_blk_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            load_len_reg <= load_len_next;
            load_ovf_reg <= load_ovf_next;
            load_blk_reg <= load_blk_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (is_payload) begin
            window_reg <= window_next;
        end
        m_reply_kind_reg <= m_reply_kind_next;
        m_matched_reg    <= m_matched_next;
        m_rule_id_reg    <= m_rule_id_next;
        m_rule_act_reg   <= m_rule_act_next;
        m_status_reg     <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_reply_kind = m_reply_kind_reg;
    assign m_matched    = m_matched_reg;
    assign m_rule_id    = m_rule_id_reg;
    assign m_rule_act   = m_rule_act_reg;
    assign m_status     = m_status_reg;

    // The table never holds more rules than it has cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(NUM_RULES))
        else $error("rule count exceeds table size");

    // Every delete word produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_DELETE) |=> m_valid)
        else $error("delete word produced no result");

    // A match verdict always carries status ok.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reply_kind == RK_MATCH) |-> (m_status == ST_OK))
        else $error("match verdict with nonzero status");

    // A successful add advances the id counter by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (is_pattern && s_last && add_ok) |=> (next_id_reg == $past(next_id_reg) + 16'd1))
        else $error("id counter did not advance on add");

endmodule
